/* hw/rtl/spiral_order_matrix_reader_unit_macros.svh */
// Assertion macros shared by the spiral order matrix reader checkers.
`ifndef SPIRAL_ORDER_MATRIX_READER_UNIT_MACROS_SVH
`define SPIRAL_ORDER_MATRIX_READER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SOMR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("spiral reader check failed");

// The consequent must hold in the cycle after the antecedent.
`define SOMR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("spiral reader check failed");

`endif

/* hw/rtl/somr_pkg.sv */
// Shared types and constants of the spiral order matrix reader.
package somr_pkg;

    localparam int unsigned MAX_ROWS_DEF    = 8;
    localparam int unsigned MAX_COLUMNS_DEF = 8;
    localparam int unsigned VALUE_WIDTH_DEF = 32;

    localparam int unsigned DIM_W       = 4;
    localparam int unsigned CFG_DATA_W  = 4;
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned ELEMENT_W   = 32;
    localparam int unsigned SPIRAL_W    = 32;

    localparam logic [DIM_W-1:0] ROW_COUNT_RESET    = 4'd8;
    localparam logic [DIM_W-1:0] COLUMN_COUNT_RESET = 4'd8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ROW_COUNT    = 1'b0,
        CFG_COLUMN_COUNT = 1'b1
    } t_cfg_index;

    typedef enum logic [1:0] {
        DIR_RIGHT = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_UP    = 2'd3
    } t_walk_dir;

    typedef enum logic {
        WALK_IDLE = 1'b0,
        WALK_RUN  = 1'b1
    } t_walk_state;

    // Control part of one load beat as it travels through the queue.
    typedef struct packed {
        logic             last;
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] cols;
    } t_load_ctrl;

    localparam int unsigned LOAD_CTRL_W = $bits(t_load_ctrl);

endpackage

/* hw/rtl/somr_queue.sv */
// Two-entry queue between the load front end and the spiral walker.
module somr_queue #(
    parameter int unsigned DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_full,
    output logic              o_empty
);

    logic [DATA_W-1:0] r_slot [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count;
    logic [1:0]        n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_slot[r_rd_ptr];
    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);

endmodule

/* hw/rtl/somr_front.sv */
// Front end: configuration registers, element counting and load classification.
module somr_front #(
    parameter int unsigned MAX_ROWS    = somr_pkg::MAX_ROWS_DEF,
    parameter int unsigned MAX_COLUMNS = somr_pkg::MAX_COLUMNS_DEF,
    parameter int unsigned VALUE_WIDTH = somr_pkg::VALUE_WIDTH_DEF,
    localparam int unsigned DEPTH  = MAX_ROWS * MAX_COLUMNS,
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [somr_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [somr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                start,
    input  logic signed [somr_pkg::ELEMENT_W-1:0] i_element_value,
    input  logic                                i_queue_full,
    input  logic                                i_run_done,
    output logic                                busy,
    output logic                                o_push,
    output logic [VALUE_WIDTH-1:0]              o_value,
    output logic [ADDR_W-1:0]                   o_addr,
    output somr_pkg::t_load_ctrl                o_ctrl
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned PROD_W = 2 * somr_pkg::DIM_W;
    localparam logic [somr_pkg::DIM_W-1:0] ROW_MAX = somr_pkg::DIM_W'(MAX_ROWS);
    localparam logic [somr_pkg::DIM_W-1:0] COL_MAX = somr_pkg::DIM_W'(MAX_COLUMNS);

    logic [somr_pkg::DIM_W-1:0] r_row_count;
    logic [somr_pkg::DIM_W-1:0] r_column_count;
    logic [CNT_W-1:0]           r_loaded_count;
    logic [CNT_W-1:0]           n_loaded_count;
    logic                       r_run_pending;
    logic [somr_pkg::DIM_W-1:0] w_rows;
    logic [somr_pkg::DIM_W-1:0] w_cols;
    logic [PROD_W-1:0]          w_total;
    logic                       w_accept;
    logic                       w_last;

    // A register value of zero acts as one, anything past the maximum as the maximum.
    function automatic logic [somr_pkg::DIM_W-1:0] clamp_dim(
        input logic [somr_pkg::DIM_W-1:0] v,
        input logic [somr_pkg::DIM_W-1:0] hi
    );
        logic [somr_pkg::DIM_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = somr_pkg::DIM_W'(1);
        end else if (v > hi) begin
            res = hi;
        end
        return res;
    endfunction

    assign w_rows   = clamp_dim(r_row_count, ROW_MAX);
    assign w_cols   = clamp_dim(r_column_count, COL_MAX);
    assign w_total  = PROD_W'(w_rows) * PROD_W'(w_cols);
    assign busy     = r_run_pending || i_queue_full;
    assign w_accept = start && !busy;

    assign n_loaded_count = r_loaded_count + CNT_W'(1);
    assign w_last         = (PROD_W'(n_loaded_count) >= w_total);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count    <= somr_pkg::ROW_COUNT_RESET;
            r_column_count <= somr_pkg::COLUMN_COUNT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                somr_pkg::CFG_ROW_COUNT: begin
                    r_row_count <= i_cfg_data;
                end
                somr_pkg::CFG_COLUMN_COUNT: begin
                    r_column_count <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded_count <= '0;
            r_run_pending  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_loaded_count <= w_last ? '0 : n_loaded_count;
            end
            if (w_accept && w_last) begin
                r_run_pending <= 1'b1;
            end else if (i_run_done) begin
                r_run_pending <= 1'b0;
            end
        end
    end

    assign o_push      = w_accept;
    assign o_value     = VALUE_WIDTH'(i_element_value);
    assign o_addr      = r_loaded_count[ADDR_W-1:0];
    assign o_ctrl.last = w_last;
    assign o_ctrl.rows = w_rows;
    assign o_ctrl.cols = w_cols;

endmodule

/* hw/rtl/somr_back.sv */
// Back end: matrix store and the spiral walk that reads it out.
module somr_back #(
    parameter int unsigned MAX_ROWS    = somr_pkg::MAX_ROWS_DEF,
    parameter int unsigned MAX_COLUMNS = somr_pkg::MAX_COLUMNS_DEF,
    parameter int unsigned VALUE_WIDTH = somr_pkg::VALUE_WIDTH_DEF,
    localparam int unsigned DEPTH  = MAX_ROWS * MAX_COLUMNS,
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_empty,
    input  logic [VALUE_WIDTH-1:0]               i_value,
    input  logic [ADDR_W-1:0]                    i_addr,
    input  somr_pkg::t_load_ctrl                 i_ctrl,
    output logic                                 o_pop,
    output logic                                 o_run_done,
    output logic                                 strobe,
    output logic signed [somr_pkg::SPIRAL_W-1:0] o_spiral_value,
    output logic                                 o_final_flag
);

    localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
    localparam int unsigned DIM_W  = somr_pkg::DIM_W;
    localparam int unsigned PROD_W = 2 * somr_pkg::DIM_W;

    logic [VALUE_WIDTH-1:0]  r_mem [DEPTH];

    somr_pkg::t_walk_state   r_state;
    somr_pkg::t_walk_state   n_state;
    somr_pkg::t_walk_dir     r_dir;
    somr_pkg::t_walk_dir     n_dir;
    logic [DIM_W-1:0]        r_pos, n_pos;
    logic [DIM_W-1:0]        r_top, n_top;
    logic [DIM_W-1:0]        r_bottom, n_bottom;
    logic [DIM_W-1:0]        r_left, n_left;
    logic [DIM_W-1:0]        r_right, n_right;
    logic [DIM_W-1:0]        r_cols;
    logic [CNT_W-1:0]        r_remaining;
    logic [DIM_W-1:0]        w_row;
    logic [DIM_W-1:0]        w_col;
    logic [PROD_W-1:0]       w_lin;
    logic [PROD_W-1:0]       w_total;
    logic                    w_start;
    logic                    w_walk;
    logic                    w_at_end;

    logic                    r_rd_valid;
    logic                    r_rd_final;
    logic [VALUE_WIDTH-1:0]  r_rd_data;

    assign w_at_end = (r_remaining == CNT_W'(1));
    assign w_total  = PROD_W'(i_ctrl.rows) * PROD_W'(i_ctrl.cols);

    always_comb begin
        n_state = r_state;
        case (r_state)
            somr_pkg::WALK_IDLE: begin
                if (!i_empty && i_ctrl.last) begin
                    n_state = somr_pkg::WALK_RUN;
                end
            end
            somr_pkg::WALK_RUN: begin
                if (w_at_end) begin
                    n_state = somr_pkg::WALK_IDLE;
                end
            end
            default: begin
                n_state = somr_pkg::WALK_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pop   = 1'b0;
        w_walk  = 1'b0;
        case (r_state)
            somr_pkg::WALK_IDLE: begin
                o_pop = !i_empty;
            end
            somr_pkg::WALK_RUN: begin
                w_walk = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign w_start = o_pop && i_ctrl.last;

    // One element per cycle; at the end of a side the bound shrinks and the
    // position jumps to the start of the next side.
    always_comb begin
        w_row    = r_top;
        w_col    = r_pos;
        n_dir    = r_dir;
        n_pos    = r_pos;
        n_top    = r_top;
        n_bottom = r_bottom;
        n_left   = r_left;
        n_right  = r_right;
        case (r_dir)
            somr_pkg::DIR_RIGHT: begin
                w_row = r_top;
                w_col = r_pos;
                if (r_pos == r_right) begin
                    n_top = r_top + DIM_W'(1);
                    n_dir = somr_pkg::DIR_DOWN;
                    n_pos = r_top + DIM_W'(1);
                end else begin
                    n_pos = r_pos + DIM_W'(1);
                end
            end
            somr_pkg::DIR_DOWN: begin
                w_row = r_pos;
                w_col = r_right;
                if (r_pos == r_bottom) begin
                    n_right = r_right - DIM_W'(1);
                    n_dir   = somr_pkg::DIR_LEFT;
                    n_pos   = r_right - DIM_W'(1);
                end else begin
                    n_pos = r_pos + DIM_W'(1);
                end
            end
            somr_pkg::DIR_LEFT: begin
                w_row = r_bottom;
                w_col = r_pos;
                if (r_pos == r_left) begin
                    n_bottom = r_bottom - DIM_W'(1);
                    n_dir    = somr_pkg::DIR_UP;
                    n_pos    = r_bottom - DIM_W'(1);
                end else begin
                    n_pos = r_pos - DIM_W'(1);
                end
            end
            somr_pkg::DIR_UP: begin
                w_row = r_pos;
                w_col = r_left;
                if (r_pos == r_top) begin
                    n_left = r_left + DIM_W'(1);
                    n_dir  = somr_pkg::DIR_RIGHT;
                    n_pos  = r_left + DIM_W'(1);
                end else begin
                    n_pos = r_pos - DIM_W'(1);
                end
            end
            default: begin
                n_dir = somr_pkg::DIR_RIGHT;
            end
        endcase
    end

    assign w_lin = PROD_W'(w_row) * PROD_W'(r_cols) + PROD_W'(w_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= somr_pkg::WALK_IDLE;
            r_dir       <= somr_pkg::DIR_RIGHT;
            r_remaining <= '0;
            r_rd_valid  <= 1'b0;
            r_rd_final  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= w_walk;
            r_rd_final <= w_walk && w_at_end;
            if (w_start) begin
                r_dir       <= somr_pkg::DIR_RIGHT;
                r_remaining <= CNT_W'(w_total);
            end else if (w_walk) begin
                r_dir       <= n_dir;
                r_remaining <= r_remaining - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_pos    <= '0;
            r_top    <= '0;
            r_left   <= '0;
            r_bottom <= i_ctrl.rows - DIM_W'(1);
            r_right  <= i_ctrl.cols - DIM_W'(1);
            r_cols   <= i_ctrl.cols;
        end else if (w_walk) begin
            r_pos    <= n_pos;
            r_top    <= n_top;
            r_left   <= n_left;
            r_bottom <= n_bottom;
            r_right  <= n_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_mem[i_addr] <= i_value;
        end
        if (w_walk) begin
            r_rd_data <= r_mem[w_lin[ADDR_W-1:0]];
        end
    end

    assign strobe         = r_rd_valid;
    assign o_final_flag   = r_rd_final;
    assign o_spiral_value = somr_pkg::SPIRAL_W'($signed(r_rd_data));
    assign o_run_done     = r_rd_valid && r_rd_final;

endmodule

/* hw/rtl/spiral_order_matrix_reader_unit.sv */
// Top level of the spiral order matrix reader: front end, queue and walker.
//
//  Channel   Handshake                 Payload
//  --------  ------------------------  -------------------------------------
//  config    i_cfg_we (no wait)        i_cfg_index, i_cfg_data
//  element   start high, busy low      i_element_value
//  result    strobe, one cycle each    o_spiral_value, o_final_flag
//
// A load beat is taken in a cycle with start high and busy low and reaches
// the store through a two-entry queue, so elements of a matrix can arrive on
// every clock while busy stays low. The beat that completes the matrix starts
// the walk: once it has passed the queue, the walker start and the registered
// store read, the results leave one per cycle, rows * cols beats in a row, set
// by the single read port of the matrix store. busy stays high from that beat
// until the final result has been shown.
// Reset is synchronous and active low; the store is not cleared, since
// every entry is written before the walk reads it. The receiver cannot
// stall; results are shown exactly once and must be taken as they come.
module spiral_order_matrix_reader_unit #(
    parameter int unsigned MAX_ROWS    = somr_pkg::MAX_ROWS_DEF,
    parameter int unsigned MAX_COLUMNS = somr_pkg::MAX_COLUMNS_DEF,
    parameter int unsigned VALUE_WIDTH = somr_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [somr_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [somr_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 start,
    input  logic signed [somr_pkg::ELEMENT_W-1:0] i_element_value,
    output logic                                 busy,
    output logic                                 strobe,
    output logic signed [somr_pkg::SPIRAL_W-1:0] o_spiral_value,
    output logic                                 o_final_flag
);

    // Store geometry follows from the largest matrix the block must hold.
    localparam int unsigned DEPTH  = MAX_ROWS * MAX_COLUMNS;
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned Q_W    = VALUE_WIDTH + ADDR_W + somr_pkg::LOAD_CTRL_W;

    logic                    w_push;
    logic                    w_pop;
    logic                    w_full;
    logic                    w_empty;
    logic                    w_run_done;
    logic [VALUE_WIDTH-1:0]  w_front_value;
    logic [ADDR_W-1:0]       w_front_addr;
    somr_pkg::t_load_ctrl    w_front_ctrl;
    logic [Q_W-1:0]          w_q_in;
    logic [Q_W-1:0]          w_q_out;
    logic [VALUE_WIDTH-1:0]  w_back_value;
    logic [ADDR_W-1:0]       w_back_addr;
    somr_pkg::t_load_ctrl    w_back_ctrl;

    // The front end counts elements and marks the beat that completes a
    // matrix; it also holds off new beats while a walk is outstanding.
    somr_front #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .start           (start),
        .i_element_value (i_element_value),
        .i_queue_full    (w_full),
        .i_run_done      (w_run_done),
        .busy            (busy),
        .o_push          (w_push),
        .o_value         (w_front_value),
        .o_addr          (w_front_addr),
        .o_ctrl          (w_front_ctrl)
    );

    assign w_q_in = {w_front_value, w_front_addr, w_front_ctrl};

    somr_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_q_in),
        .i_pop   (w_pop),
        .o_data  (w_q_out),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    assign w_back_value = w_q_out[Q_W-1 -: VALUE_WIDTH];
    assign w_back_addr  = w_q_out[somr_pkg::LOAD_CTRL_W +: ADDR_W];
    assign w_back_ctrl  = somr_pkg::t_load_ctrl'(w_q_out[somr_pkg::LOAD_CTRL_W-1:0]);

    // The back end writes each beat into the store and, on the last one,
    // walks the matrix clockwise from the outside in.
    somr_back #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (w_empty),
        .i_value        (w_back_value),
        .i_addr         (w_back_addr),
        .i_ctrl         (w_back_ctrl),
        .o_pop          (w_pop),
        .o_run_done     (w_run_done),
        .strobe         (strobe),
        .o_spiral_value (o_spiral_value),
        .o_final_flag   (o_final_flag)
    );

endmodule

/* hw/rtl/somr_checker.sv */
// Port-level checks of the spiral order matrix reader and their binding.
`include "spiral_order_matrix_reader_unit_macros.svh"

module somr_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic strobe,
    input logic o_final_flag
);

    // The final flag only rides on a result beat.
    `SOMR_ASSERT_SAME(a_final_on_beat, i_clk, i_rst_n, o_final_flag, strobe)

    // A run's results come back to back until the final one.
    `SOMR_ASSERT_NEXT(a_run_contiguous, i_clk, i_rst_n, strobe && !o_final_flag, strobe)

    // The block reports busy for as long as results are going out.
    `SOMR_ASSERT_SAME(a_busy_in_run, i_clk, i_rst_n, strobe, busy)

    // An accepted element never produces a result in the very next cycle.
    `SOMR_ASSERT_NEXT(a_no_early_beat, i_clk, i_rst_n, start && !busy, !strobe)

endmodule

bind spiral_order_matrix_reader_unit somr_checker u_somr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .strobe       (strobe),
    .o_final_flag (o_final_flag)
);

/* tb/spiral_order_matrix_reader_unit_test.sv */
// Self-checking testbench for the spiral order matrix reader unit.
module spiral_order_matrix_reader_unit_test;

    // Run length, idling and watchdog settings.
    localparam int ELEMENT_TARGET = 230;   // total beats sent over the whole run
    localparam int CALM_FROM      = 200;   // no more idling from this beat on
    localparam int SETTLE_CYCLES  = 8;     // queue plus walker latency, with margin
    localparam int WATCHDOG_LIMIT = 500;   // cycles with no handshake at all
    localparam int PRINT_LIMIT    = 40;
    localparam int STORE_DEPTH    = somr_pkg::MAX_ROWS_DEF * somr_pkg::MAX_COLUMNS_DEF;

    // One expected beat of the spiral output.
    typedef struct packed {
        logic signed [somr_pkg::SPIRAL_W-1:0] value;
        logic                                 last;
    } t_spiral_beat;

    // One row of the directed stimulus table.
    typedef enum logic {
        ROW_ELEMENT = 1'b0,
        ROW_CONFIG  = 1'b1
    } t_row_kind;

    typedef struct packed {
        t_row_kind                             kind;
        logic [somr_pkg::DIM_W-1:0]            rows;
        logic [somr_pkg::DIM_W-1:0]            cols;
        logic signed [somr_pkg::ELEMENT_W-1:0] value;
        logic                                  typed;
        logic signed [somr_pkg::SPIRAL_W-1:0]  want_value;
        logic                                  want_final;
    } t_stim_row;

    // Clock, reset and block inputs, all known from time zero.
    logic                                   i_clk = 1'b0;
    logic                                   i_rst_n = 1'b0;
    logic                                   i_cfg_we = 1'b0;
    logic [somr_pkg::CFG_INDEX_W-1:0]       i_cfg_index = '0;
    logic [somr_pkg::CFG_DATA_W-1:0]        i_cfg_data = '0;
    logic                                   start = 1'b0;
    logic signed [somr_pkg::ELEMENT_W-1:0]  i_element_value = '0;
    logic                                   busy;
    logic                                   strobe;
    logic signed [somr_pkg::SPIRAL_W-1:0]   o_spiral_value;
    logic                                   o_final_flag;

    // Shadow copy of the block: settings, matrix store and load count.
    logic [somr_pkg::DIM_W-1:0]             row_setting = somr_pkg::ROW_COUNT_RESET;
    logic [somr_pkg::DIM_W-1:0]             col_setting = somr_pkg::COLUMN_COUNT_RESET;
    logic signed [somr_pkg::ELEMENT_W-1:0]  shadow_matrix [STORE_DEPTH];
    int                                     shadow_loaded = 0;
    t_spiral_beat                           spiral_expect [$];

    // Bookkeeping for the summary and the verdict.
    int                           mismatches = 0;
    int                           elements_sent = 0;
    int                           matrices_done = 0;
    int                           beats_checked = 0;
    int                           quiet_cycles = 0;
    bit                           no_idle = 1'b0;

    t_stim_row                    directed_rows [28];

    spiral_order_matrix_reader_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .start          (start),
        .i_element_value(i_element_value),
        .busy           (busy),
        .strobe         (strobe),
        .o_spiral_value (o_spiral_value),
        .o_final_flag   (o_final_flag)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_LIMIT) begin
            $display("MISMATCH at %0t: %s", $realtime, what);
        end
        mismatches++;
    endtask

    // A dimension register of 0 behaves as 1, anything above the maximum as the maximum.
    function automatic int clamp_dim(input logic [somr_pkg::DIM_W-1:0] setting,
                                     input int limit);
        if (setting == 0) return 1;
        if (int'(setting) > limit) return limit;
        return int'(setting);
    endfunction

    // Appends one expected beat at the tail of the expectation list.
    function automatic void expect_beat(input logic signed [somr_pkg::SPIRAL_W-1:0] value,
                                        input logic last);
        t_spiral_beat beat;
        beat.value = value;
        beat.last  = last;
        spiral_expect.insert(spiral_expect.size(), beat);
    endfunction

    // Takes one accepted element into the shadow store. When the load count reaches or
    // passes the element total under the current settings, the whole matrix is walked
    // clockwise from the outside in and every beat is queued as expected output.
    function automatic void predict_spiral(input logic signed [somr_pkg::ELEMENT_W-1:0] value);
        int                  rows;
        int                  cols;
        int                  total;
        int                  top;
        int                  bottom;
        int                  left;
        int                  right;
        int                  i;
        int                  n;
        somr_pkg::t_walk_dir dir;
        rows  = clamp_dim(row_setting, somr_pkg::MAX_ROWS_DEF);
        cols  = clamp_dim(col_setting, somr_pkg::MAX_COLUMNS_DEF);
        total = rows * cols;
        if (shadow_loaded < STORE_DEPTH) shadow_matrix[shadow_loaded] = value;
        shadow_loaded = (shadow_loaded + 1) % 128;
        if (shadow_loaded < total) return;
        shadow_loaded = 0;
        top    = 0;
        bottom = rows - 1;
        left   = 0;
        right  = cols - 1;
        n      = 0;
        dir    = somr_pkg::DIR_RIGHT;
        while (top <= bottom && left <= right) begin
            case (dir)
                somr_pkg::DIR_RIGHT: begin
                    for (i = left; i <= right; i++) begin
                        n++;
                        expect_beat(shadow_matrix[top * cols + i], n == total);
                    end
                    top++;
                end
                somr_pkg::DIR_DOWN: begin
                    for (i = top; i <= bottom; i++) begin
                        n++;
                        expect_beat(shadow_matrix[i * cols + right], n == total);
                    end
                    right--;
                end
                somr_pkg::DIR_LEFT: begin
                    for (i = right; i >= left; i--) begin
                        n++;
                        expect_beat(shadow_matrix[bottom * cols + i], n == total);
                    end
                    bottom--;
                end
                default: begin
                    for (i = bottom; i >= top; i--) begin
                        n++;
                        expect_beat(shadow_matrix[i * cols + left], n == total);
                    end
                    left++;
                end
            endcase
            dir = somr_pkg::t_walk_dir'(2'(dir + 1));
        end
        matrices_done++;
    endfunction

    function automatic logic signed [somr_pkg::ELEMENT_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly small matrices, some up to the maximum, a few out-of-range settings.
    function automatic logic [somr_pkg::DIM_W-1:0] pick_dim();
        int unsigned sel;
        sel = $urandom_range(0, 11);
        if (sel == 0) return '0;
        if (sel == 1) return somr_pkg::DIM_W'($urandom_range(9, 15));
        if (sel <= 3) return somr_pkg::DIM_W'($urandom_range(5, 8));
        return somr_pkg::DIM_W'($urandom_range(1, 4));
    endfunction

    // Idle bursts of random length on the sender side, none in calm stretches.
    function automatic int unsigned pick_gap();
        if (no_idle || elements_sent >= CALM_FROM) return 0;
        if ($urandom_range(0, 3) != 0) return 0;
        return $urandom_range(1, 10);
    endfunction

    // Presents one element and holds it until the block takes the beat. start stays
    // high when the next beat follows at once, so it is never lowered and raised in
    // the same step. A typed expectation replaces the single beat a 1x1 run gives.
    task automatic push_element(input logic signed [somr_pkg::ELEMENT_W-1:0] value,
                                input logic typed,
                                input logic signed [somr_pkg::SPIRAL_W-1:0] want_value,
                                input logic want_final);
        int unsigned gap;
        start <= 1'b1;
        i_element_value <= value;
        do @(posedge i_clk); while (busy !== 1'b0);
        predict_spiral(value);
        if (typed) spiral_expect[spiral_expect.size() - 1] = '{want_value, want_final};
        elements_sent++;
        gap = pick_gap();
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Brings the block to rest: no beat pending and the load queue drained.
    task automatic settle();
        start <= 1'b0;
        while (spiral_expect.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes the row count register, then the column count register.
    task automatic write_dims(input logic [somr_pkg::DIM_W-1:0] rows_val,
                              input logic [somr_pkg::DIM_W-1:0] cols_val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= somr_pkg::CFG_ROW_COUNT;
        i_cfg_data  <= rows_val;
        @(posedge i_clk);
        row_setting = rows_val;
        i_cfg_index <= somr_pkg::CFG_COLUMN_COUNT;
        i_cfg_data  <= cols_val;
        @(posedge i_clk);
        col_setting = cols_val;
        i_cfg_we    <= 1'b0;
    endtask

    // Sends random elements until the current matrix has been fully loaded.
    task automatic load_matrix();
        do push_element(pick_value(), 1'b0, '0, 1'b0); while (shadow_loaded != 0);
    endtask

    // Every strobed beat is taken at the edge that ends its cycle and compared with
    // the oldest expectation; the receiver has no way to hold it off.
    always @(posedge i_clk) begin
        t_spiral_beat want;
        if (i_rst_n && strobe) begin
            if (spiral_expect.size() == 0) begin
                report_mismatch($sformatf("beat %h with nothing expected", o_spiral_value));
            end else begin
                want = spiral_expect.pop_front();
                beats_checked++;
                if (o_spiral_value !== want.value)
                    report_mismatch($sformatf("value %h, expected %h",
                                              o_spiral_value, want.value));
                if (o_final_flag !== want.last)
                    report_mismatch($sformatf("final flag %b, expected %b",
                                              o_final_flag, want.last));
            end
        end
    end

    // Watchdog: any handshake on any port counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || strobe || i_cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d beats still expected", spiral_expect.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int total;

        // Directed table. Typed expectations are given only for 1x1 runs, where the
        // one result is the element itself with the final flag set.
        directed_rows = '{
            // Single-element matrix with the extremes of the signed range, zero and minus one.
            '{ROW_CONFIG,  4'd1,  4'd1, 32'sh0000_0000, 1'b0, 32'sh0000_0000, 1'b0},
            '{ROW_ELEMENT, 4'd0,  4'd0, 32'sh7FFF_FFFF, 1'b1, 32'sh7FFF_FFFF, 1'b1},
            '{ROW_ELEMENT, 4'd0,  4'd0, 32'sh8000_0000, 1'b1, 32'sh8000_0000, 1'b1},
            '{ROW_ELEMENT, 4'd0,  4'd0, 32'sh0000_0000, 1'b1, 32'sh0000_0000, 1'b1},
            '{ROW_ELEMENT, 4'd0,  4'd0, 32'shFFFF_FFFF, 1'b1, 32'shFFFF_FFFF, 1'b1},
            // Zero in both registers behaves as a 1x1 matrix.
            '{ROW_CONFIG,  4'd0,  4'd0, 32'sh0000_0000, 1'b0, 32'sh0000_0000, 1'b0},
            '{ROW_ELEMENT, 4'd0,  4'd0, 32'sh1234_5678, 1'b1, 32'sh1234_5678, 1'b1},
            // Rows above the maximum clamp to eight, columns of zero to one: 8x1.
            '{ROW_CONFIG,  4'd15, 4'd0, 32'sh0000_0000, 1'b0, 32'sh0000_0000, 1'b0},
            '{ROW_ELEMENT, 4'd0,  4'd0, 32'shA5A5_5A5A, 1'b0, 32'sh0000_0000, 1'b0},
            '{ROW_ELEMENT, 4'd0,  4'd0, 32'sh5A5A_A5A5, 1'b0, 32'sh0000_0000, 1'b0},
            '{ROW_ELEMENT, 4'd0,  4'd0, 32'sh0000_0001, 1'b0, 32'sh0000_0000, 1'b0},
            '{ROW_ELEMENT, 4'd0,  4'd0, 32'sh4000_0000, 1'b0, 32'sh0000_0000, 1'b0},
            '{ROW_ELEMENT, 4'd0,  4'd0, 32'shC000_0000, 1'b0, 32'sh0000_0000, 1'b0},
            '{ROW_ELEMENT, 4'd0,  4'd0, 32'sh0000_FFFF, 1'b0, 32'sh0000_0000, 1'b0},
            '{ROW_ELEMENT, 4'd0,  4'd0, 32'shFFFF_0000, 1'b0, 32'sh0000_0000, 1'b0},
            '{ROW_ELEMENT, 4'd0,  4'd0, 32'sh8000_0001, 1'b0, 32'sh0000_0000, 1'b0},
            // Shrinking the matrix part way through a load: the next beat already
            // passes the new total and emits the first two stored elements.
            '{ROW_CONFIG,  4'd2,  4'd2, 32'sh0000_0000, 1'b0, 32'sh0000_0000, 1'b0},
            '{ROW_ELEMENT, 4'd0,  4'd0, 32'sh0000_0011, 1'b0, 32'sh0000_0000, 1'b0},
            '{ROW_ELEMENT, 4'd0,  4'd0, 32'sh0000_0022, 1'b0, 32'sh0000_0000, 1'b0},
            '{ROW_CONFIG,  4'd1,  4'd2, 32'sh0000_0000, 1'b0, 32'sh0000_0000, 1'b0},
            '{ROW_ELEMENT, 4'd0,  4'd0, 32'sh0000_0033, 1'b0, 32'sh0000_0000, 1'b0},
            // A 2x3 matrix turns at every corner.
            '{ROW_CONFIG,  4'd2,  4'd3, 32'sh0000_0000, 1'b0, 32'sh0000_0000, 1'b0},
            '{ROW_ELEMENT, 4'd0,  4'd0, 32'sh0000_0001, 1'b0, 32'sh0000_0000, 1'b0},
            '{ROW_ELEMENT, 4'd0,  4'd0, 32'sh0000_0002, 1'b0, 32'sh0000_0000, 1'b0},
            '{ROW_ELEMENT, 4'd0,  4'd0, 32'sh0000_0003, 1'b0, 32'sh0000_0000, 1'b0},
            '{ROW_ELEMENT, 4'd0,  4'd0, 32'sh0000_0004, 1'b0, 32'sh0000_0000, 1'b0},
            '{ROW_ELEMENT, 4'd0,  4'd0, 32'sh0000_0005, 1'b0, 32'sh0000_0000, 1'b0},
            '{ROW_ELEMENT, 4'd0,  4'd0, 32'sh0000_0006, 1'b0, 32'sh0000_0000, 1'b0}
        };

        // Synchronous reset is held low from time zero, then released before the first load.
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The reset settings give the largest matrix: one full 8x8 run first.
        load_matrix();

        foreach (directed_rows[k]) begin
            if (directed_rows[k].kind == ROW_CONFIG) begin
                settle();
                write_dims(directed_rows[k].rows, directed_rows[k].cols);
            end else begin
                push_element(directed_rows[k].value, directed_rows[k].typed,
                             directed_rows[k].want_value, directed_rows[k].want_final);
            end
        end

        // Random phases: new dimensions, sometimes a change in the middle of a load,
        // then one to three whole matrices of random content, kept within the budget.
        while (elements_sent < ELEMENT_TARGET) begin
            no_idle = ($urandom_range(0, 4) == 0);
            settle();
            write_dims(pick_dim(), pick_dim());
            total = clamp_dim(row_setting, somr_pkg::MAX_ROWS_DEF) *
                    clamp_dim(col_setting, somr_pkg::MAX_COLUMNS_DEF);
            if ($urandom_range(0, 5) == 0 && total > 1 &&
                elements_sent + 2 * STORE_DEPTH <= ELEMENT_TARGET) begin
                repeat ($urandom_range(1, total - 1)) push_element(pick_value(), 1'b0, '0, 1'b0);
                settle();
                write_dims(pick_dim(), pick_dim());
                total = clamp_dim(row_setting, somr_pkg::MAX_ROWS_DEF) *
                        clamp_dim(col_setting, somr_pkg::MAX_COLUMNS_DEF);
                load_matrix();
            end
            repeat ($urandom_range(1, 3)) begin
                if (elements_sent + total <= ELEMENT_TARGET) load_matrix();
            end
        end

        // Wait for the last beats and a little beyond the walk latency.
        settle();

        $display("Sent %0d elements forming %0d matrices, with dimensions from 1x1 to 8x8,",
                 elements_sent, matrices_done);
        $display("clamped settings and mid-load changes; %0d spiral beats compared.",
                 beats_checked);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
